### rtl/prt_pkg.sv
// Shared types and constants for the polyline time resampler.
// Used by the top level of the block; depends on nothing.
`default_nettype none

package prt_pkg;

    // Width of stored times and coordinates (signed Q16.16).
    localparam int VALUE_BITS = 32;
    // Sample time: 32-bit start plus a 31 x 16 bit product, with a sign bit.
    localparam int TIME_BITS = 49;
    localparam int COUNT_BITS = 16;
    localparam int STEP_BITS = 31;
    localparam int INDEX_BITS = 16;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [STEP_BITS-1:0] STEP_RESET = 31'd65536;

    // Action codes of an input item.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_START_TIME = 1'b0;
    localparam logic CFG_TIME_STEP = 1'b1;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_REJECT = 3'd1,
        ST_FULL = 3'd2,
        ST_EMPTY = 3'd3,
        ST_CLAMP = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_SAMP,
        S_RANGE,
        S_SRCH,
        S_SCMP,
        S_RDA,
        S_RDB,
        S_RDC,
        S_START,
        S_DIV,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

### rtl/prt_ram.sv
// Simple dual-port synchronous memory with a registered read.
// Holds point times or coordinates; uses no package items.
`default_nettype none

module prt_ram #(
    parameter int W = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [W-1:0]             i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];

    // One write and one read per cycle; read data is registered and appears in the cycle after the address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/prt_muldiv.sv
// Bit-serial unit computing floor(m * n / d) for n <= d, one bit of m a cycle.
// Used for interpolation ratios and the sample count; uses no package items.
`default_nettype none

module prt_muldiv #(
    parameter int W = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_m,
    input  wire logic [W-1:0] i_n,
    input  wire logic [W-1:0] i_d,
    output logic              o_busy,
    output logic      [W-1:0] o_q
);

    localparam int CNTW = $clog2(W);

    logic            r_busy;
    logic [CNTW-1:0] r_cnt;
    logic [W-1:0]    r_m;
    logic [W-1:0]    r_n;
    logic [W-1:0]    r_d;
    logic [W-1:0]    r_r;
    logic [W-1:0]    r_q;
    logic [W+1:0]    sum;
    logic [W+1:0]    d1;
    logic [W+1:0]    d2;
    logic [W+1:0]    n_r;
    logic [1:0]      digit;

    // One step: shift the remainder, add n for a set bit, then take out d once or twice.
    always_comb begin
        d1 = {2'b00, r_d};
        d2 = {1'b0, r_d, 1'b0};
        sum = {1'b0, r_r, 1'b0} + (r_m[W-1] ? {2'b00, r_n} : '0);
        if (sum >= d2) begin
            n_r = sum - d2;
            digit = 2'd2;
        end else if (sum >= d1) begin
            n_r = sum - d1;
            digit = 2'd1;
        end else begin
            n_r = sum;
            digit = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CNTW'(W - 1);
            r_m <= i_m;
            r_n <= i_n;
            r_d <= i_d;
            r_r <= '0;
            r_q <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_m <= {r_m[W-2:0], 1'b0};
            r_r <= n_r[W-1:0];
            r_q <= {r_q[W-2:0], 1'b0} + {{(W-2){1'b0}}, digit};
        end
    end

    assign o_busy = r_busy;
    assign o_q = r_q;

endmodule

`default_nettype wire

### rtl/polyline_time_resampler_unit.sv
// Top level of the polyline time resampler: control sequencer, point memories
// and serial ratio units. Depends on prt_pkg, prt_ram and prt_muldiv.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | i_in_valid, o_in_stall, i_action .. index | item in
//  out     | o_out_valid, i_out_stall, o_status .. cnt | result out
//  cfg     | i_cfg_valid, o_cfg_ready, index, data     | register write
//
// A load passes through the 32-step serial ratio units; so does a sample, which
// first runs a binary search over the time memory (states S_SRCH and S_SCMP)
// when it falls between points, and skips it at or beyond either end. A new
// item is taken only once the previous one has finished.
// Reset is synchronous and empties the store; memory contents stay undefined.
// A result waiting under a stall does not block the next item from entering.
`default_nettype none

module polyline_time_resampler_unit #(
    parameter int MAX_POINTS = 1024
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_action,
    input  wire logic                           i_first_point,
    input  wire logic [prt_pkg::VALUE_BITS-1:0] i_point_time,
    input  wire logic [prt_pkg::VALUE_BITS-1:0] i_point_x,
    input  wire logic [prt_pkg::VALUE_BITS-1:0] i_point_y,
    input  wire logic [prt_pkg::VALUE_BITS-1:0] i_point_z,
    input  wire logic [prt_pkg::INDEX_BITS-1:0] i_sample_index,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic      [2:0]                     o_status,
    output logic      [prt_pkg::VALUE_BITS-1:0] o_sample_x,
    output logic      [prt_pkg::VALUE_BITS-1:0] o_sample_y,
    output logic      [prt_pkg::VALUE_BITS-1:0] o_sample_z,
    output logic      [prt_pkg::COUNT_BITS-1:0] o_sample_count,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic                           i_cfg_index,
    input  wire logic [prt_pkg::VALUE_BITS-1:0] i_cfg_data
);

    import prt_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int VB = VALUE_BITS;
    localparam int TW = TIME_BITS;

    t_state r_state;
    t_state n_state;

    // Configuration and store bookkeeping.
    logic signed [VB-1:0]   r_start_time;
    logic [STEP_BITS-1:0]   r_time_step;
    logic [CW-1:0]          r_count;
    logic signed [VB-1:0]   r_first_time;
    logic signed [VB-1:0]   r_last_time;

    // Latched item.
    logic                   r_first_pt;
    logic signed [VB-1:0]   r_pt_time;
    logic [3*VB-1:0]        r_pt_xyz;
    logic [INDEX_BITS-1:0]  r_k;

    // Sample working registers.
    logic signed [TW-1:0]   r_t;
    t_status                r_status;
    logic [AW-1:0]          r_lo;
    logic [AW-1:0]          r_hi;
    logic [AW-1:0]          r_mid;
    logic signed [VB-1:0]   r_tlo;
    logic signed [VB-1:0]   r_thi;
    logic                   r_interp;
    logic [3*VB-1:0]        r_a;
    logic [3*VB-1:0]        r_b;
    logic [2:0]             r_neg;
    logic                   r_cdiff_neg;

    // Output register.
    logic                   r_out_valid;
    t_status                r_out_status;
    logic [3*VB-1:0]        r_out_xyz;
    logic [COUNT_BITS-1:0]  r_out_count;

    // Memory ports.
    logic                   mem_we_t;
    logic                   mem_we_c;
    logic [AW-1:0]          mem_waddr;
    logic [AW-1:0]          mem_raddr;
    logic [VB-1:0]          time_rdata;
    logic [3*VB-1:0]        coord_rdata;

    // Ratio unit ports; lane 3 computes the sample count.
    logic                   lane_start;
    logic [VB-1:0]          lane_m [4];
    logic [VB-1:0]          lane_n [4];
    logic [VB-1:0]          lane_d [4];
    logic [VB-1:0]          lane_q [4];
    logic [3:0]             lane_busy;

    logic                   in_accept;
    logic                   out_free;
    logic [STEP_BITS-1:0]   step_eff;
    logic [CW-1:0]          load_n;
    logic                   load_reject;
    logic                   load_equal;
    logic                   load_full;
    logic [AW-1:0]          srch_mid;
    logic                   srch_more;
    logic signed [TW-1:0]   t_first_ext;
    logic signed [TW-1:0]   t_last_ext;
    logic signed [TW-1:0]   t_lo_ext;
    logic signed [TW-1:0]   t_rd_ext;
    logic signed [VB:0]     cnt_diff;
    logic signed [VB:0]     co_diff [3];
    logic [VB-1:0]          fin_xyz [3];
    logic [COUNT_BITS-1:0]  fin_count;

    assign in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign step_eff = (r_time_step == '0) ? STEP_BITS'(1) : r_time_step;

    assign t_first_ext = TW'(r_first_time);
    assign t_last_ext = TW'(r_last_time);
    assign t_lo_ext = TW'(r_tlo);
    assign t_rd_ext = TW'($signed(time_rdata));

    // Load decision against the newest stored point.
    always_comb begin
        load_n = r_first_pt ? '0 : r_count;
        load_reject = (load_n != '0) && (r_pt_time < r_last_time);
        load_equal = (load_n != '0) && (r_pt_time == r_last_time);
        load_full = (load_n >= CW'(MAX_POINTS));
    end

    assign srch_more = (r_hi - r_lo) > AW'(1);
    assign srch_mid = r_lo + ((r_hi - r_lo) >> 1);

    // Memory write and read addressing.
    always_comb begin
        mem_we_t = 1'b0;
        mem_we_c = 1'b0;
        mem_waddr = load_n[AW-1:0];
        mem_raddr = r_lo;
        if (r_state == S_LOAD && !load_reject) begin
            if (load_equal) begin
                mem_we_c = 1'b1;
                mem_waddr = AW'(load_n - 1'b1);
            end else if (!load_full) begin
                mem_we_t = 1'b1;
                mem_we_c = 1'b1;
            end
        end
        case (r_state)
            S_SRCH:  mem_raddr = srch_mid;
            S_RDB:   mem_raddr = r_hi;
            default: mem_raddr = r_lo;
        endcase
    end

    prt_ram #(.W(VB), .DEPTH(MAX_POINTS)) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we_t),
        .i_waddr (mem_waddr),
        .i_wdata (r_pt_time),
        .i_raddr (mem_raddr),
        .o_rdata (time_rdata)
    );

    prt_ram #(.W(3 * VB), .DEPTH(MAX_POINTS)) u_coord_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we_c),
        .i_waddr (mem_waddr),
        .i_wdata (r_pt_xyz),
        .i_raddr (mem_raddr),
        .o_rdata (coord_rdata)
    );

    // Operands of the ratio units.
    always_comb begin
        lane_start = (r_state == S_START);
        for (int c = 0; c < 3; c++) begin
            co_diff[c] = $signed({r_b[c*VB+VB-1], r_b[c*VB +: VB]})
                       - $signed({r_a[c*VB+VB-1], r_a[c*VB +: VB]});
            if (r_interp) begin
                lane_m[c] = co_diff[c][VB] ? VB'(-co_diff[c]) : co_diff[c][VB-1:0];
                lane_n[c] = VB'(r_t - t_lo_ext);
                lane_d[c] = VB'($signed({r_thi[VB-1], r_thi}) - $signed({r_tlo[VB-1], r_tlo}));
            end else begin
                lane_m[c] = '0;
                lane_n[c] = '0;
                lane_d[c] = VB'(1);
            end
        end
        cnt_diff = $signed({r_last_time[VB-1], r_last_time})
                 - $signed({r_start_time[VB-1], r_start_time});
        lane_m[3] = cnt_diff[VB] ? VB'(-cnt_diff) : cnt_diff[VB-1:0];
        lane_n[3] = VB'(1);
        lane_d[3] = VB'(step_eff);
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        prt_muldiv #(.W(VB)) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (lane_start),
            .i_m     (lane_m[g]),
            .i_n     (lane_n[g]),
            .i_d     (lane_d[g]),
            .o_busy  (lane_busy[g]),
            .o_q     (lane_q[g])
        );
    end

    // Final position and saturated sample count.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            fin_xyz[c] = r_neg[c] ? (r_a[c*VB +: VB] - lane_q[c])
                                  : (r_a[c*VB +: VB] + lane_q[c]);
        end
        if (r_count == '0) begin
            fin_count = '0;
        end else if (r_cdiff_neg) begin
            fin_count = (lane_q[3] == '0) ? COUNT_BITS'(1) : '0;
        end else if (lane_q[3] >= VB'(COUNT_MAX)) begin
            fin_count = COUNT_MAX;
        end else begin
            fin_count = lane_q[3][COUNT_BITS-1:0] + 1'b1;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = (i_action == ACT_LOAD) ? S_LOAD : S_SAMP;
                end
            end
            S_LOAD: n_state = S_START;
            S_SAMP: n_state = (r_count == '0) ? S_START : S_RANGE;
            S_RANGE: begin
                if (r_t <= t_first_ext || r_t >= t_last_ext) begin
                    n_state = S_RDA;
                end else begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: n_state = srch_more ? S_SCMP : S_RDA;
            S_SCMP: n_state = S_SRCH;
            S_RDA: n_state = S_RDB;
            S_RDB: n_state = r_interp ? S_RDC : S_START;
            S_RDC: n_state = S_START;
            S_START: n_state = S_DIV;
            S_DIV: n_state = (lane_busy == '0) ? S_FIN : S_DIV;
            S_FIN: n_state = out_free ? S_IDLE : S_FIN;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_start_time <= '0;
            r_time_step <= STEP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_START_TIME) begin
                    r_start_time <= i_cfg_data;
                end else if (i_cfg_index == CFG_TIME_STEP) begin
                    r_time_step <= i_cfg_data[STEP_BITS-1:0];
                end
            end
            if (r_state == S_LOAD) begin
                if (!load_reject && !load_equal && !load_full) begin
                    r_count <= load_n + 1'b1;
                end else begin
                    r_count <= load_n;
                end
            end
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    r_first_pt <= i_first_point;
                    r_pt_time <= i_point_time;
                    r_pt_xyz <= {i_point_z, i_point_y, i_point_x};
                    r_k <= i_sample_index;
                    r_status <= ST_OK;
                end
            end
            S_LOAD: begin
                r_a <= '0;
                r_interp <= 1'b0;
                if (load_reject) begin
                    r_status <= ST_REJECT;
                end else if (load_equal) begin
                    r_status <= ST_OK;
                end else if (load_full) begin
                    r_status <= ST_FULL;
                end else begin
                    r_last_time <= r_pt_time;
                    if (load_n == '0) begin
                        r_first_time <= r_pt_time;
                    end
                end
            end
            S_SAMP: begin
                r_t <= TW'(r_start_time) + $signed(TW'(step_eff) * TW'(r_k));
                r_a <= '0;
                r_interp <= 1'b0;
                if (r_count == '0) begin
                    r_status <= ST_EMPTY;
                end
            end
            S_RANGE: begin
                if (r_t <= t_first_ext) begin
                    r_lo <= '0;
                end else if (r_t >= t_last_ext) begin
                    r_lo <= AW'(r_count - 1'b1);
                    if (r_t > t_last_ext) begin
                        r_status <= ST_CLAMP;
                    end
                end else begin
                    r_lo <= '0;
                    r_hi <= AW'(r_count - 1'b1);
                    r_tlo <= r_first_time;
                    r_thi <= r_last_time;
                end
            end
            S_SRCH: begin
                r_mid <= srch_mid;
                if (!srch_more) begin
                    r_interp <= (t_lo_ext != r_t);
                end
            end
            S_SCMP: begin
                if (t_rd_ext <= r_t) begin
                    r_lo <= r_mid;
                    r_tlo <= time_rdata;
                end else begin
                    r_hi <= r_mid;
                    r_thi <= time_rdata;
                end
            end
            S_RDB: r_a <= coord_rdata;
            S_RDC: r_b <= coord_rdata;
            S_START: begin
                for (int c = 0; c < 3; c++) begin
                    r_neg[c] <= r_interp && co_diff[c][VB];
                end
                r_cdiff_neg <= cnt_diff[VB];
            end
            S_FIN: begin
                if (out_free) begin
                    r_out_status <= r_status;
                    r_out_xyz <= {fin_xyz[2], fin_xyz[1], fin_xyz[0]};
                    r_out_count <= fin_count;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_status = r_out_status;
    assign o_sample_x = r_out_xyz[VB-1:0];
    assign o_sample_y = r_out_xyz[2*VB-1:VB];
    assign o_sample_z = r_out_xyz[3*VB-1:2*VB];
    assign o_sample_count = r_out_count;

`ifndef SYNTHESIS
    // The store never holds more points than the memory has entries.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS))
        else $error("point count exceeds memory depth");

    // A new result only appears after the finishing step.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_FIN)
        else $error("result raised outside the finishing step");

    // The search window stays ordered while a probe is in flight.
    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCMP |-> r_lo < r_hi)
        else $error("search window collapsed");

    // The serial units are only started when all are idle.
    a_lane_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_START |-> lane_busy == '0)
        else $error("ratio unit restarted while busy");
`endif

endmodule

`default_nettype wire
